// File: src/idh_pkg.sv
// Shared types, constants and compare function for the indexed deadline heap.
`default_nettype none
package idh_pkg;
   localparam int DL_W      = 64;
   localparam int CPU_W     = 6;
   localparam int CPU_SPACE = 64;
   localparam int OUT_W     = 7;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   localparam logic signed [OUT_W-1:0] NO_CPU = 7'h7F;

   typedef struct packed {
      logic [1:0]       op;
      logic [CPU_W-1:0] cpu;
      logic [DL_W-1:0]  deadline;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] top_cpu;
      logic [OUT_W-1:0]        entry_count;
      logic                    matched;
      logic                    ignored;
   } rsp_type;

   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [CPU_W-1:0] cpu;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOKUP, ST_FETCH, ST_UP_RD, ST_UP_CMP,
      ST_DN_RD, ST_DN_CMP, ST_FINISH, ST_TOP_RD, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_CAPTURE, ACT_LOOKUP, ACT_FETCH, ACT_UP_RD, ACT_UP_CMP,
      ACT_DN_RD, ACT_DN_CMP, ACT_FINISH, ACT_TOP_RD, ACT_LOAD
   } act_type;

   typedef struct packed {
      act_type act;
   } cmd_type;

   typedef struct packed {
      logic fetch_up;
      logic fetch_down;
      logic down_after;
      logic up_at_root;
      logic up_moved;
      logic dn_leaf;
      logic dn_moved;
      logic rsp_free;
   } status_type;

   function automatic logic below(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b,
                                  input logic mode);
      return mode ? (a > b) : (a < b);
   endfunction
endpackage
`default_nettype wire

// File: src/indexed_deadline_heap_top.sv
// Top level of the indexed deadline heap: sequencer plus heap datapath.
// Check, unknown op, remove of an absent cpu and removal of the tail slot go straight
// to the top read; a sift reads and compares each level examined, then writes the entry
// back, and a set can climb up to six levels.
// Throughput: one transaction at a time, the next taken the cycle after the response loads.
// Reset: synchronous; empties the heap, marks every cpu absent and sets order mode 0.
`default_nettype none
module indexed_deadline_heap_top #(
   parameter int NUM_CPUS = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  idh_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output idh_pkg::rsp_type   rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_data
);
   idh_pkg::cmd_type    cmd;
   idh_pkg::status_type status;

   assign csr_ready = 1'b1;

   idh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   idh_datapath #(.NUM_CPUS(NUM_CPUS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

// File: src/idh_ctrl.sv
// Sequencer that steps the heap datapath through lookup, sift and response.
`default_nettype none
module idh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  idh_pkg::status_type     status,
   output idh_pkg::cmd_type        cmd
);
   idh_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idh_pkg::ST_IDLE: begin
            if (req_valid) state_in = idh_pkg::ST_LOOKUP;
         end
         idh_pkg::ST_LOOKUP: state_in = idh_pkg::ST_FETCH;
         idh_pkg::ST_FETCH: begin
            if (status.fetch_up)        state_in = idh_pkg::ST_UP_RD;
            else if (status.fetch_down) state_in = idh_pkg::ST_DN_RD;
            else                        state_in = idh_pkg::ST_TOP_RD;
         end
         idh_pkg::ST_UP_RD: begin
            if (!status.up_at_root)     state_in = idh_pkg::ST_UP_CMP;
            else if (status.down_after) state_in = idh_pkg::ST_DN_RD;
            else                        state_in = idh_pkg::ST_FINISH;
         end
         idh_pkg::ST_UP_CMP: begin
            if (status.up_moved)        state_in = idh_pkg::ST_UP_RD;
            else if (status.down_after) state_in = idh_pkg::ST_DN_RD;
            else                        state_in = idh_pkg::ST_FINISH;
         end
         idh_pkg::ST_DN_RD: begin
            state_in = status.dn_leaf ? idh_pkg::ST_FINISH : idh_pkg::ST_DN_CMP;
         end
         idh_pkg::ST_DN_CMP: begin
            state_in = status.dn_moved ? idh_pkg::ST_DN_RD : idh_pkg::ST_FINISH;
         end
         idh_pkg::ST_FINISH: state_in = idh_pkg::ST_TOP_RD;
         idh_pkg::ST_TOP_RD: state_in = idh_pkg::ST_DONE;
         idh_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = idh_pkg::ST_IDLE;
         end
         default: state_in = idh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd.act   = idh_pkg::ACT_NONE;
      unique case (state_ff)
         idh_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.act = idh_pkg::ACT_CAPTURE;
         end
         idh_pkg::ST_LOOKUP: cmd.act = idh_pkg::ACT_LOOKUP;
         idh_pkg::ST_FETCH:  cmd.act = idh_pkg::ACT_FETCH;
         idh_pkg::ST_UP_RD:  cmd.act = idh_pkg::ACT_UP_RD;
         idh_pkg::ST_UP_CMP: cmd.act = idh_pkg::ACT_UP_CMP;
         idh_pkg::ST_DN_RD:  cmd.act = idh_pkg::ACT_DN_RD;
         idh_pkg::ST_DN_CMP: cmd.act = idh_pkg::ACT_DN_CMP;
         idh_pkg::ST_FINISH: cmd.act = idh_pkg::ACT_FINISH;
         idh_pkg::ST_TOP_RD: cmd.act = idh_pkg::ACT_TOP_RD;
         idh_pkg::ST_DONE: begin
            if (status.rsp_free) cmd.act = idh_pkg::ACT_LOAD;
         end
         default: cmd.act = idh_pkg::ACT_NONE;
      endcase
   end
endmodule
`default_nettype wire

// File: src/idh_datapath.sv
// Heap storage, cpu slot map, sift compare logic and response register.
`default_nettype none
module idh_datapath #(
   parameter int NUM_CPUS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  idh_pkg::cmd_type     cmd,
   output idh_pkg::status_type  status,
   input  idh_pkg::req_type     req_data,
   input  wire logic            csr_write,
   input  wire logic            csr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output idh_pkg::rsp_type     rsp_data
);
   localparam int DEPTH = (NUM_CPUS < idh_pkg::CPU_SPACE) ? NUM_CPUS : idh_pkg::CPU_SPACE;
   localparam int SW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam int IW    = SW + 2;

   idh_pkg::entry_type heap_mem [DEPTH];
   logic [SW-1:0]      map_mem  [DEPTH];

   idh_pkg::req_type   req_ff, req_in;
   logic               mode_ff, mode_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [SW-1:0]      idx_ff, idx_in;
   idh_pkg::entry_type elem_ff, elem_in;
   logic               down_after_ff, down_after_in;
   logic               matched_ff, matched_in;
   logic               ignored_ff, ignored_in;
   logic [SW-1:0]      slot_ff;
   idh_pkg::entry_type rda_ff, rdb_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   idh_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               rda_en, rdb_en;
   logic [SW-1:0]      rda_addr, rdb_addr;
   logic               heap_we, map_we;
   logic [SW-1:0]      heap_wa;
   idh_pkg::entry_type heap_wd;
   logic [SW-1:0]      map_wa, map_wd;

   logic               cpu_ok, present, set_new, fell, rm_sift;
   logic [SW-1:0]      cpu_idx, last, parent;
   logic [IW-1:0]      lchild, rchild, count_x;
   logic               l_ok, r_ok, best_l, best_r;
   logic [idh_pkg::DL_W-1:0] cand_dl;
   idh_pkg::entry_type child;
   logic [SW-1:0]      child_idx;

   always_comb begin
      cpu_ok    = 32'(req_ff.cpu) < NUM_CPUS;
      cpu_idx   = req_ff.cpu[SW-1:0];
      present   = cpu_ok && valid_ff[cpu_idx];
      last      = SW'(count_ff - 1'b1);
      set_new   = cpu_ok && !present && (32'(count_ff) < DEPTH);
      fell      = idh_pkg::below(req_ff.deadline, rda_ff.deadline, mode_ff);
      rm_sift   = present && (slot_ff < last);
      parent    = SW'((idx_ff - 1'b1) >> 1);
      lchild    = {1'b0, idx_ff, 1'b1};
      rchild    = lchild + 1'b1;
      count_x   = IW'(count_ff);
      l_ok      = lchild < count_x;
      r_ok      = rchild < count_x;
      best_l    = idh_pkg::below(elem_ff.deadline, rda_ff.deadline, mode_ff);
      cand_dl   = best_l ? rda_ff.deadline : elem_ff.deadline;
      best_r    = r_ok && idh_pkg::below(cand_dl, rdb_ff.deadline, mode_ff);
      child     = best_r ? rdb_ff : rda_ff;
      child_idx = best_r ? rchild[SW-1:0] : lchild[SW-1:0];
   end

   always_comb begin
      status.fetch_up   = 1'b0;
      status.fetch_down = 1'b0;
      case (req_ff.op)
         idh_pkg::OP_SET: begin
            status.fetch_up   = set_new || (cpu_ok && present && !fell);
            status.fetch_down = cpu_ok && present && fell;
         end
         idh_pkg::OP_REMOVE: status.fetch_up = rm_sift;
         default: ;
      endcase
      status.down_after = down_after_ff;
      status.up_at_root = idx_ff == '0;
      status.up_moved   = idh_pkg::below(rda_ff.deadline, elem_ff.deadline, mode_ff);
      status.dn_leaf    = !l_ok;
      status.dn_moved   = best_l || best_r;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      req_in        = req_ff;
      mode_in       = csr_write ? csr_data : mode_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      elem_in       = elem_ff;
      down_after_in = down_after_ff;
      matched_in    = matched_ff;
      ignored_in    = ignored_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rda_en = 1'b0; rda_addr = '0;
      rdb_en = 1'b0; rdb_addr = '0;
      heap_we = 1'b0; heap_wa = idx_ff; heap_wd = elem_ff;
      map_we  = 1'b0; map_wa = elem_ff.cpu[SW-1:0]; map_wd = idx_ff;
      unique case (cmd.act)
         idh_pkg::ACT_CAPTURE: req_in = req_data;
         idh_pkg::ACT_LOOKUP: begin
            rda_en   = 1'b1;
            rda_addr = (req_ff.op == idh_pkg::OP_REMOVE) ? last : slot_ff;
         end
         idh_pkg::ACT_FETCH: begin
            matched_in    = (req_ff.op == idh_pkg::OP_CHECK) && present
                            && (rda_ff.deadline == req_ff.deadline);
            ignored_in    = (req_ff.op == idh_pkg::OP_REMOVE) && !present;
            down_after_in = (req_ff.op == idh_pkg::OP_REMOVE) && present;
            elem_in.deadline = req_ff.deadline;
            elem_in.cpu      = req_ff.cpu;
            if (req_ff.op == idh_pkg::OP_SET) begin
               if (set_new) begin
                  idx_in   = SW'(count_ff);
                  count_in = count_ff + 1'b1;
               end else begin
                  idx_in = slot_ff;
               end
            end else if (req_ff.op == idh_pkg::OP_REMOVE && present) begin
               count_in          = count_ff - 1'b1;
               valid_in[cpu_idx] = 1'b0;
               idx_in            = slot_ff;
               elem_in           = rda_ff;
            end
         end
         idh_pkg::ACT_UP_RD: begin
            rda_en   = 1'b1;
            rda_addr = parent;
         end
         idh_pkg::ACT_UP_CMP: begin
            if (status.up_moved) begin
               heap_we = 1'b1; heap_wd = rda_ff;
               map_we  = 1'b1; map_wa = rda_ff.cpu[SW-1:0];
               idx_in  = parent;
            end
         end
         idh_pkg::ACT_DN_RD: begin
            rda_en   = 1'b1;
            rda_addr = lchild[SW-1:0];
            rdb_en   = 1'b1;
            rdb_addr = r_ok ? rchild[SW-1:0] : lchild[SW-1:0];
         end
         idh_pkg::ACT_DN_CMP: begin
            if (status.dn_moved) begin
               heap_we = 1'b1; heap_wd = child;
               map_we  = 1'b1; map_wa = child.cpu[SW-1:0];
               idx_in  = child_idx;
            end
         end
         idh_pkg::ACT_FINISH: begin
            heap_we = 1'b1;
            map_we  = 1'b1;
            valid_in[elem_ff.cpu[SW-1:0]] = 1'b1;
         end
         idh_pkg::ACT_TOP_RD: begin
            rda_en   = 1'b1;
            rda_addr = '0;
         end
         idh_pkg::ACT_LOAD: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.top_cpu     = (count_ff != '0) ? $signed({1'b0, rda_ff.cpu})
                                                       : idh_pkg::NO_CPU;
            rsp_data_in.entry_count = idh_pkg::OUT_W'(count_ff);
            rsp_data_in.matched     = matched_ff;
            rsp_data_in.ignored     = ignored_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      elem_ff       <= elem_in;
      down_after_ff <= down_after_in;
      matched_ff    <= matched_in;
      ignored_ff    <= ignored_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      if (rda_en)  rda_ff <= heap_mem[rda_addr];
      if (rdb_en)  rdb_ff <= heap_mem[rdb_addr];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (cmd.act == idh_pkg::ACT_CAPTURE) slot_ff <= map_mem[req_data.cpu[SW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

// File: src/idh_checker.sv
// Port-level checks for the indexed deadline heap, bound to the top level.
`default_nettype none
module idh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input idh_pkg::req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input idh_pkg::rsp_type rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic        csr_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.entry_count == '0) == (rsp_data.top_cpu == idh_pkg::NO_CPU)))
      else $error("top cpu disagrees with entry count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 7'd64)
      else $error("entry count out of range");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.matched && rsp_data.ignored))
      else $error("matched and ignored both set");
endmodule

bind indexed_deadline_heap_top idh_checker u_idh_checker (.*);
`default_nettype wire
